FILE: src/convex_zone_point_test_core_macros.svh
// Assertion macros shared by the convex zone point test checker.
`ifndef CONVEX_ZONE_POINT_TEST_CORE_MACROS_SVH
`define CONVEX_ZONE_POINT_TEST_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CZPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CZPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/czpt_pkg.sv
// Package with the shared constants of the convex zone point test block.
package czpt_pkg;

  // Width of the vertex count register and its value after reset.
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 5'd3;

  // Configuration port geometry and register index.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // Request types.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Defaults of the top-level parameters.
  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_WIDTH_DEF = 16;

endpackage

FILE: src/convex_zone_point_test_core.sv
// Convex zone point test: vertex store, edge walk sequencer and result register.
//
// The block holds the vertices of one convex zone in a single-port-read,
// single-port-write memory and tests query points against it. A vertex write
// leaves the block idle. A query whose point is flagged as a zone vertex, or
// one made with a vertex count of zero, goes straight to the done state,
// loads its result once the output register is free and frees the block then.
// Any other query reads the memory once per cycle, n + 1 reads for n
// vertices, through a three-stage pipeline (edge differences, the two
// cross-product multiplies, sign compare). Its result is loaded into the
// output register after the last sign compare, once that register is free;
// the query occupies the block until then, so a stalled output keeps it
// busy longer. New requests are held off while a query is in progress, but a
// finished result waiting in the output register does not block the next
// request.
module convex_zone_point_test_core #(
  parameter int MAX_VERTICES = czpt_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = czpt_pkg::COORD_WIDTH_DEF,
  parameter int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  // Request channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [IDX_W-1:0]              vertex_index,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic                          query_is_vertex,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          inside_res,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [czpt_pkg::PADDR_W-1:0]  paddr,
  input  logic [czpt_pkg::PDATA_W-1:0]  pwdata,
  output logic [czpt_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import czpt_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int EXT_W = CFG_W + CNT_W;
  localparam int DIF_W = COORD_WIDTH + 1;
  localparam int PRD_W = 2 * DIF_W;
  localparam int ENT_W = 2 * COORD_WIDTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Configuration register.
  logic [CFG_W-1:0] vertex_count;

  // Sequencer state.
  logic [1:0]       state;
  logic             rd_active;
  logic [CNT_W-1:0] rd_step;
  logic             res;

  // Memory and read pipeline.
  logic [ENT_W-1:0] vmem [MAX_VERTICES];
  logic [ENT_W-1:0] rdata;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_vld, rd_first, rd_last;
  logic signed [COORD_WIDTH-1:0] px, py, prev_x, prev_y, cur_x, cur_y;
  logic             d_vld, d_last;
  logic signed [DIF_W-1:0] dx1, dy1, dx2, dy2;
  logic             m_vld, m_last;
  logic signed [PRD_W-1:0] p1, p2;
  logic             sign_set, sign_pos, fail;
  logic             k_pos, fail_next;

  logic             cfg_wr, in_acc, out_load;
  logic [CNT_W-1:0] eff_cnt, last_idx, step_prev;
  logic [EXT_W-1:0] cnt_ext;
  logic             wr_ok;

  // Effective vertex count, clipped to the store depth.
  assign cnt_ext  = EXT_W'(vertex_count);
  assign eff_cnt  = (cnt_ext > EXT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                      : cnt_ext[CNT_W-1:0];
  assign last_idx = eff_cnt - 1'b1;

  // Configuration port: always ready, one register wherever address bit 2 is clear.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? PDATA_W'(vertex_count) : '0;

  // Request handshake: a new request is taken only while the sequencer is idle.
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_ok    = (CNT_W'(vertex_index) < eff_cnt);

  // Read address: the last vertex first, then every vertex in order.
  assign rd_en     = (state == ST_WALK) && rd_active;
  assign step_prev = rd_step - 1'b1;
  assign rd_addr   = (rd_step == '0) ? last_idx[IDX_W-1:0] : step_prev[IDX_W-1:0];

  assign cur_x = rdata[ENT_W-1:COORD_WIDTH];
  assign cur_y = rdata[COORD_WIDTH-1:0];

  // Sign of the cross product, zero counting as positive, and the running verdict.
  always_comb begin
    k_pos     = (p1 >= p2);
    fail_next = fail;
    if (m_vld && sign_set && (k_pos != sign_pos)) begin
      fail_next = 1'b1;
    end
  end

  // The result register is loaded when it is empty or being emptied.
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  // Vertex memory with registered read data.
  always_ff @(posedge clk) begin
    if (in_acc && (req_type == REQ_WRITE) && wr_ok) begin
      vmem[vertex_index] <= {x_coord, y_coord};
    end
    if (rd_en) begin
      rdata <= vmem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
      state        <= ST_IDLE;
      rd_active    <= 1'b0;
      rd_vld       <= 1'b0;
      d_vld        <= 1'b0;
      m_vld        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_VERTEX_COUNT)) begin
        vertex_count <= pwdata[CFG_W-1:0];
      end

      // Pipeline valid flags.
      rd_vld <= rd_en;
      d_vld  <= rd_vld && !rd_first;
      m_vld  <= d_vld;

      case (state)
        ST_IDLE: begin
          if (in_acc && (req_type == REQ_QUERY)) begin
            if (query_is_vertex || (eff_cnt == '0)) begin
              state <= ST_DONE;
            end else begin
              state     <= ST_WALK;
              rd_active <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          if (rd_en && (rd_step == eff_cnt)) begin
            rd_active <= 1'b0;
          end
          if (m_vld && m_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Result register.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // Query set-up.
    if (in_acc && (req_type == REQ_QUERY)) begin
      px       <= x_coord;
      py       <= y_coord;
      rd_step  <= '0;
      sign_set <= 1'b0;
      fail     <= 1'b0;
      res      <= !query_is_vertex;
    end else begin
      if (rd_en) begin
        rd_step <= rd_step + 1'b1;
      end
      if (m_vld) begin
        sign_set <= 1'b1;
        if (!sign_set) begin
          sign_pos <= k_pos;
        end
        fail <= fail_next;
        if (m_last) begin
          res <= !fail_next;
        end
      end
    end

    // Read stage flags.
    rd_first <= rd_en && (rd_step == '0);
    rd_last  <= rd_en && (rd_step == eff_cnt);

    // Edge differences from the previous vertex.
    if (rd_vld) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
      d_last <= rd_last;
      dx1    <= $signed({cur_x[COORD_WIDTH-1], cur_x}) -
                $signed({prev_x[COORD_WIDTH-1], prev_x});
      dy1    <= $signed({cur_y[COORD_WIDTH-1], cur_y}) -
                $signed({prev_y[COORD_WIDTH-1], prev_y});
      dx2    <= $signed({px[COORD_WIDTH-1], px}) -
                $signed({prev_x[COORD_WIDTH-1], prev_x});
      dy2    <= $signed({py[COORD_WIDTH-1], py}) -
                $signed({prev_y[COORD_WIDTH-1], prev_y});
    end

    // Cross-product terms.
    m_last <= d_last;
    p1     <= dx1 * dy2;
    p2     <= dy1 * dx2;

    if (out_load) begin
      inside_res <= res;
    end
  end

endmodule

FILE: src/czpt_checker.sv
// Port-level checker for the convex zone point test block, with its bind.
`include "convex_zone_point_test_core_macros.svh"

module czpt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic req_type,
  input logic out_valid,
  input logic out_stall,
  input logic inside_res
);
  import czpt_pkg::*;

  // A result held back by the receiver stays put.
  `CZPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(inside_res), "stalled result changed")

  // A query keeps the block busy in the following cycle.
  `CZPT_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && (req_type == REQ_QUERY), in_stall, "query did not occupy the block")

  // A vertex write finishes at once and leaves the block free.
  `CZPT_ASSERT_NEXT(a_write_free, in_valid && !in_stall && (req_type == REQ_WRITE), !in_stall, "vertex write held the block")

  // A new result only ever follows a period of work on a query.
  `CZPT_ASSERT_NOW(a_res_after_busy, $rose(out_valid), $past(in_stall), "result appeared without a query in progress")

endmodule

bind convex_zone_point_test_core czpt_checker u_czpt_checker (.*);

FILE: verif/tb_convex_zone_point_test_core.sv
// Self-checking testbench for the convex zone point test core.
module tb_convex_zone_point_test_core;
  import czpt_pkg::*;

  localparam int ZONE_MAX    = MAX_VERTICES_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 40;
  localparam int PHASE_REQS  = 36;

  typedef struct packed {
    logic              kind;
    logic [3:0]        index;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic              at_vertex;
  } zone_req_t;

  // Block ports; the inputs are at known values from time zero.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               req_type = REQ_WRITE;
  logic [3:0]         vertex_index = '0;
  logic signed [15:0] x_coord = '0;
  logic signed [15:0] y_coord = '0;
  logic               query_is_vertex = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               inside_res;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Zone state as the block should hold it.
  logic [CFG_W-1:0]   cfg_count = VERTEX_COUNT_RESET;
  logic signed [15:0] zone_x [ZONE_MAX];
  logic signed [15:0] zone_y [ZONE_MAX];

  // Zone as planned by the request generator.
  logic signed [15:0] plan_x [ZONE_MAX];
  logic signed [15:0] plan_y [ZONE_MAX];
  int                 plan_cx = 0;
  int                 plan_cy = 0;
  int                 plan_r = 0;

  zone_req_t pending_reqs [$];
  logic      inside_expected [$];
  zone_req_t cur_req;

  int  requests_queued = 0;
  int  requests_taken = 0;
  int  writes_taken = 0;
  int  queries_taken = 0;
  int  inside_seen = 0;
  int  settings_written = 0;
  int  fail_count = 0;
  int  reported = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  send_calm = 1'b0;
  bit  recv_calm = 1'b0;
  bit  quiet = 1'b0;
  bit  hold_request = 1'b0;
  bit  hold_started = 1'b0;

  int phase_counts [12] = '{16, 31, 1, 0, 2, 5, 17, 8, 4, 3, 12, 16};

  convex_zone_point_test_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .vertex_index    (vertex_index),
    .x_coord         (x_coord),
    .y_coord         (y_coord),
    .query_is_vertex (query_is_vertex),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .inside_res      (inside_res),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Number of vertices in use; larger settings saturate at the store depth.
  function automatic int zone_n();
    return (cfg_count > ZONE_MAX) ? ZONE_MAX : int'(cfg_count);
  endfunction

  // Walks the zone edges from the last vertex round to the first and checks
  // that every cross product has the same sign, zero counting as positive.
  function automatic logic edge_walk(logic signed [15:0] qx, logic signed [15:0] qy);
    int     n;
    int     prev;
    int     i;
    longint ex;
    longint ey;
    longint rx;
    longint ry;
    bit     sign_set;
    bit     sign_pos;
    bit     pos;
    logic   res;
    n = zone_n();
    prev = (n != 0) ? n - 1 : 0;
    res = 1'b1;
    sign_set = 1'b0;
    sign_pos = 1'b0;
    for (i = 0; i < n; i++) begin
      ex = longint'(zone_x[i]) - longint'(zone_x[prev]);
      ey = longint'(zone_y[i]) - longint'(zone_y[prev]);
      rx = longint'(qx) - longint'(zone_x[prev]);
      ry = longint'(qy) - longint'(zone_y[prev]);
      pos = (ex * ry >= ey * rx);
      if (!sign_set) begin
        sign_set = 1'b1;
        sign_pos = pos;
      end else if (pos != sign_pos) begin
        res = 1'b0;
      end
      prev = i;
    end
    return res;
  endfunction

  // Applies one accepted request to the zone and records any result it owes.
  task automatic predict_request(zone_req_t r);
    logic want;
    if (r.kind == REQ_WRITE) begin
      writes_taken++;
      if (int'(r.index) < zone_n()) begin
        zone_x[r.index] = r.px;
        zone_y[r.index] = r.py;
      end
    end else begin
      want = r.at_vertex ? 1'b0 : edge_walk(r.px, r.py);
      inside_expected.push_back(want);
      queries_taken++;
      if (want) inside_seen++;
    end
    requests_taken++;
  endtask

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Unit circle in steps of 22.5 degrees, scaled by 1024.
  function automatic int unit_cos(int k);
    case (k % 16)
      0:  return 1024;
      1:  return 946;
      2:  return 724;
      3:  return 392;
      4:  return 0;
      5:  return -392;
      6:  return -724;
      7:  return -946;
      8:  return -1024;
      9:  return -946;
      10: return -724;
      11: return -392;
      12: return 0;
      13: return 392;
      14: return 724;
      default: return 946;
    endcase
  endfunction

  task automatic queue_req(logic kind, logic [3:0] idx, logic signed [15:0] qx,
                           logic signed [15:0] qy, logic flag);
    zone_req_t r;
    r.kind = kind;
    r.index = idx;
    r.px = qx;
    r.py = qy;
    r.at_vertex = flag;
    pending_reqs.push_back(r);
    requests_queued++;
  endtask

  // A vertex write; the generator keeps its own copy of the zone.
  task automatic queue_write(logic [3:0] idx, logic signed [15:0] qx,
                             logic signed [15:0] qy, logic flag);
    if (int'(idx) < zone_n()) begin
      plan_x[idx] = qx;
      plan_y[idx] = qy;
    end
    queue_req(REQ_WRITE, idx, qx, qy, flag);
  endtask

  // Waits until every queued request is taken and every result has come back.
  task automatic wait_drained();
    while (requests_taken != requests_queued || inside_expected.size() != 0)
      @(posedge clk);
  endtask

  // Register write over the configuration port while the block is idle.
  task automatic set_vertex_count(int unsigned v);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * REG_VERTEX_COUNT);
    pwdata <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_count = v[CFG_W-1:0];
    settings_written++;
  endtask

  // Writes a fresh convex zone: vertices picked in order from a circle,
  // turned either way and started at a random corner.
  task automatic queue_polygon();
    int dirs [ZONE_MAX];
    int n;
    int need;
    int cnt;
    int k;
    int i;
    int j;
    int rot;
    bit rev;
    n = zone_n();
    if (n == 0) return;
    plan_r = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(64, 32767);
    plan_cx = int'($urandom_range(0, 2 * (32767 - plan_r))) - (32767 - plan_r);
    plan_cy = int'($urandom_range(0, 2 * (32767 - plan_r))) - (32767 - plan_r);
    need = n;
    cnt = 0;
    for (k = 0; k < 16; k++) begin
      if ($urandom_range(0, 15 - k) < need) begin
        dirs[cnt] = k;
        cnt++;
        need--;
      end
    end
    rot = $urandom_range(0, n - 1);
    rev = 1'($urandom_range(0, 1));
    for (i = 0; i < n; i++) begin
      j = rev ? n - 1 - ((i + rot) % n) : (i + rot) % n;
      queue_write(i[3:0], clamp16(plan_cx + plan_r * unit_cos(dirs[j]) / 1024),
                  clamp16(plan_cy + plan_r * unit_cos(dirs[j] + 12) / 1024),
                  1'($urandom_range(0, 1)));
      // Now and then a write past the zone that must leave it alone.
      if (n < ZONE_MAX && $urandom_range(0, 7) == 0)
        queue_write(4'($urandom_range(n, ZONE_MAX - 1)), 16'($urandom), 16'($urandom), 1'b0);
    end
  endtask

  // A query placed near the current zone: at, beside or between its corners,
  // near its centre, or somewhere in the box around it.
  task automatic queue_probe();
    int n;
    int v;
    int w;
    int span;
    n = zone_n();
    if (n == 0) begin
      queue_req(REQ_QUERY, 4'($urandom), 16'($urandom), 16'($urandom),
                1'($urandom_range(0, 1)));
      return;
    end
    v = $urandom_range(0, n - 1);
    w = (v + 1) % n;
    span = plan_r * 3 / 2 + 16;
    case ($urandom_range(0, 5))
      0: queue_req(REQ_QUERY, 4'($urandom),
                   clamp16(int'(plan_x[v]) + int'($urandom_range(0, 2)) - 1),
                   clamp16(int'(plan_y[v]) + int'($urandom_range(0, 2)) - 1), 1'b0);
      1: queue_req(REQ_QUERY, 4'($urandom), plan_x[v], plan_y[v],
                   1'($urandom_range(0, 1)));
      2: queue_req(REQ_QUERY, 4'($urandom),
                   clamp16((int'(plan_x[v]) + int'(plan_x[w])) / 2),
                   clamp16((int'(plan_y[v]) + int'(plan_y[w])) / 2), 1'b0);
      3: queue_req(REQ_QUERY, 4'($urandom),
                   clamp16(plan_cx + int'($urandom_range(0, 4)) - 2),
                   clamp16(plan_cy + int'($urandom_range(0, 4)) - 2), 1'b0);
      default: queue_req(REQ_QUERY, 4'($urandom),
                         clamp16(plan_cx + int'($urandom_range(0, 2 * span)) - span),
                         clamp16(plan_cy + int'($urandom_range(0, 2 * span)) - span), 1'b0);
    endcase
  endtask

  // Request driver: takes items from the pending queue, with random gaps.
  always @(posedge clk) begin : req_driver
    logic load_next;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
      load_next = !in_valid;
      if (in_valid && !in_stall) begin
        predict_request(cur_req);
        load_next = 1'b1;
      end
      if (load_next) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && !send_calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= cur_req.kind;
          vertex_index <= cur_req.index;
          x_coord <= cur_req.px;
          y_coord <= cur_req.py;
          query_is_vertex <= cur_req.at_vertex;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall: random bursts, calm stretches and one long hold-off.
  always @(posedge clk) begin : result_stall
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) recv_calm = !recv_calm;
      if (hold_request && !hold_started) begin
        hold_started = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && !recv_calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result monitor: each result against the oldest outstanding expectation.
  always @(posedge clk) begin : result_monitor
    logic want;
    if (!rst && out_valid && !out_stall) begin
      if (inside_expected.size() == 0) begin
        fail_count++;
        if (reported < 10)
          $display("unexpected result: inside_res %0b with no query outstanding", inside_res);
        reported++;
      end else begin
        want = inside_expected.pop_front();
        if (inside_res !== want) begin
          fail_count++;
          if (reported < 10)
            $display("mismatch: inside_res expected %0b got %0b", want, inside_res);
          reported++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, inside_expected.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    int start;
    bit drained;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset setting of three vertices: a triangle across the full range.
    queue_write(4'd0, 16'sh8000, 16'sh8000, 1'b1);
    queue_write(4'd1, 16'sh7fff, 16'sh8000, 1'b0);
    queue_write(4'd2, 16'sh8000, 16'sh7fff, 1'b0);
    queue_write(4'd3, 16'sh7fff, 16'sh7fff, 1'b0);
    queue_write(4'd15, 16'sh0000, 16'sh0000, 1'b1);
    queue_req(REQ_QUERY, 4'd0, -16'sd100, -16'sd100, 1'b0);
    queue_req(REQ_QUERY, 4'd0, 16'sh0000, 16'sh0000, 1'b0);
    queue_req(REQ_QUERY, 4'd0, 16'sh0000, -16'sd1, 1'b0);
    queue_req(REQ_QUERY, 4'd0, 16'sh7fff, 16'sh7fff, 1'b0);
    queue_req(REQ_QUERY, 4'd15, 16'sh8000, 16'sh8000, 1'b0);
    queue_req(REQ_QUERY, 4'd7, 16'sh7fff, 16'sh8000, 1'b0);
    queue_req(REQ_QUERY, 4'd0, 16'sh8000, 16'sh7fff, 1'b1);
    queue_req(REQ_QUERY, 4'd0, -16'sd100, -16'sd100, 1'b1);
    queue_req(REQ_QUERY, 4'd0, 16'sh8000, 16'sh0000, 1'b0);
    queue_req(REQ_QUERY, 4'd0, 16'sh8010, 16'sh8010, 1'b0);

    // No vertices at all: writes vanish and queries report inside unless flagged.
    set_vertex_count(0);
    queue_write(4'd0, 16'sh1234, 16'sh4321, 1'b0);
    queue_req(REQ_QUERY, 4'd0, 16'sh3039, -16'sd1, 1'b0);
    queue_req(REQ_QUERY, 4'd0, 16'sh3039, -16'sd1, 1'b1);
    queue_req(REQ_QUERY, 4'd0, 16'sh8000, 16'sh7fff, 1'b0);

    // Random phases over a range of vertex counts, the extremes among them.
    for (p = 0; p < 12; p++) begin
      set_vertex_count(phase_counts[p]);
      if (p == 11) quiet = 1'b1;
      start = requests_queued;
      drained = 1'b0;
      queue_polygon();
      if (p == 0) hold_request = 1'b1;
      while (requests_queued - start < PHASE_REQS) begin
        if (!drained && requests_queued - start >= PHASE_REQS / 2) begin
          wait_drained();
          drained = 1'b1;
        end
        case ($urandom_range(0, 11))
          0: queue_polygon();
          1: queue_write(4'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom_range(0, 1)));
          2: queue_req(REQ_QUERY, 4'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom_range(0, 1)));
          default: queue_probe();
        endcase
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d requests: %0d vertex writes, %0d queries (%0d inside)",
             requests_taken, writes_taken, queries_taken, inside_seen);
    $display("over %0d vertex count settings with %0d failures", settings_written, fail_count);
    if (fail_count == 0 && inside_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
